### hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/tnp_pkg.sv
// types, constants and helpers of the name component parser
package tnp_pkg;

	localparam int MAX_NAME_LENGTH   = 2048;
	localparam int CACHED_COMPONENTS = 16;

	// internal byte position width follows the maximum name length
	localparam int POS_W = $clog2(MAX_NAME_LENGTH + 1);

	// fixed field widths
	localparam int TLEN_W = 16;
	localparam int BYTE_W = 8;
	localparam int ST_W   = 3;
	localparam int END_W  = 12;
	localparam int IDX_W  = 11;
	localparam int CNT_W  = 12;
	localparam int NUM_W  = 32;

	// input modes
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_DATA  = 1'b1;

	// result kinds
	localparam logic KIND_COMP  = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	// status codes
	localparam logic [ST_W-1:0] ST_OK         = 3'd0;
	localparam logic [ST_W-1:0] ST_TOO_LONG   = 3'd1;
	localparam logic [ST_W-1:0] ST_INCOMPLETE = 3'd2;
	localparam logic [ST_W-1:0] ST_OVERFLOW   = 3'd3;
	localparam logic [ST_W-1:0] ST_BAD_TYPE   = 3'd4;
	localparam logic [ST_W-1:0] ST_BAD_DIGEST = 3'd5;

	typedef struct packed {
		logic             kind;
		logic [ST_W-1:0]  status;
		logic [END_W-1:0] comp_end_offset;
		logic [IDX_W-1:0] comp_index;
		logic             offset_cached;
		logic [CNT_W-1:0] comp_total;
		logic             digest_present;
	} tnp_result_t;

	// up to two results from one word, first in r0
	typedef struct packed {
		logic        v0;
		logic        v1;
		tnp_result_t r0;
		tnp_result_t r1;
	} tnp_push_t;

	function automatic tnp_result_t make_final(input logic [ST_W-1:0] status,
			input logic [CNT_W-1:0] total, input logic digest);
		tnp_result_t r;
		r                 = '0;
		r.kind            = KIND_FINAL;
		r.status          = status;
		r.comp_total      = total;
		r.digest_present  = digest;
		return r;
	endfunction

endpackage

### hdl/tnp_ifs.sv
// valid/ready channel interfaces for input bytes and results
interface tnp_item_if
	import tnp_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              mode;
	logic [TLEN_W-1:0] total_length;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output mode, output total_length, output data_byte,
		input ready);
	modport sink (input valid, input mode, input total_length, input data_byte,
		output ready);
endinterface

interface tnp_result_if
	import tnp_pkg::*;
;
	logic             valid;
	logic             ready;
	logic             kind;
	logic [ST_W-1:0]  status;
	logic [END_W-1:0] comp_end_offset;
	logic [IDX_W-1:0] comp_index;
	logic             offset_cached;
	logic [CNT_W-1:0] comp_total;
	logic             digest_present;

	modport source (output valid, output kind, output status, output comp_end_offset,
		output comp_index, output offset_cached, output comp_total,
		output digest_present, input ready);
	modport sink (input valid, input kind, input status, input comp_end_offset,
		input comp_index, input offset_cached, input comp_total,
		input digest_present, output ready);
endinterface

### hdl/tnp_parse_core.sv
// input register and parser state, one word processed per cycle while the queue has room
module tnp_parse_core
	import tnp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	tnp_item_if.sink     item,
	input  logic         room,
	output tnp_push_t    push
);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_TYPE  = 2'd1;
	localparam logic [1:0] PH_LEN   = 2'd2;
	localparam logic [1:0] PH_VALUE = 2'd3;

	// first bytes of the two- and four-byte number forms
	localparam logic [BYTE_W-1:0] NUM_2B = 8'd253;
	localparam logic [BYTE_W-1:0] NUM_4B = 8'd254;

	localparam logic [NUM_W-1:0] DIGEST_TYPE = 32'd1;
	localparam logic [NUM_W-1:0] DIGEST_LEN  = 32'd32;

	// input stage
	logic              valid_s1;
	logic              mode_s1;
	logic [TLEN_W-1:0] tlen_s1;
	logic [BYTE_W-1:0] byte_s1;

	// parser state
	logic [1:0]       phase_q, phase_d;
	logic [2:0]       hbl_q, hbl_d;
	logic [NUM_W-1:0] acc_q, acc_d;
	logic             bad_type_q, bad_type_d;
	logic             is_digest_q, is_digest_d;
	logic [POS_W-1:0] vleft_q, vleft_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] decl_q, decl_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             digest_q, digest_d;

	logic             advance;
	logic [POS_W-1:0] rem;
	logic [POS_W-1:0] pos_n;
	logic [NUM_W-1:0] acc_n;
	logic             num_done;
	logic [NUM_W-1:0] num_val;
	logic [POS_W:0]   end_w;
	logic             far;
	logic             digest_n;
	logic [CNT_W-1:0] count_n;

	assign advance    = valid_s1 && room;
	assign item.ready = !valid_s1 || room;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			mode_s1 <= item.mode;
			tlen_s1 <= item.total_length;
			byte_s1 <= item.data_byte;
		end
	end

	// shared header and bounds arithmetic
	assign rem      = decl_q - pos_q;
	assign pos_n    = pos_q + POS_W'(1);
	assign acc_n    = {acc_q[NUM_W-BYTE_W-1:0], byte_s1};
	assign num_done = (hbl_q == 3'd0) ? (byte_s1 < NUM_2B) : (hbl_q == 3'd1);
	assign num_val  = (hbl_q == 3'd0) ? {{(NUM_W-BYTE_W){1'b0}}, byte_s1} : acc_n;
	assign end_w    = {1'b0, pos_n} + {1'b0, num_val[POS_W-1:0]};
	assign far      = (|num_val[NUM_W-1:POS_W]) || (end_w > {1'b0, decl_q});
	assign digest_n = digest_q | is_digest_q;
	assign count_n  = count_q + CNT_W'(1);

	// next state and results
	always_comb begin
		phase_d     = phase_q;
		hbl_d       = hbl_q;
		acc_d       = acc_q;
		bad_type_d  = bad_type_q;
		is_digest_d = is_digest_q;
		vleft_d     = vleft_q;
		pos_d       = pos_q;
		decl_d      = decl_q;
		count_d     = count_q;
		digest_d    = digest_q;
		push        = '0;

		if (advance) begin
			if (mode_s1 == MODE_START) begin
				phase_d     = PH_TYPE;
				hbl_d       = '0;
				acc_d       = '0;
				bad_type_d  = 1'b0;
				is_digest_d = 1'b0;
				vleft_d     = '0;
				pos_d       = '0;
				decl_d      = '0;
				count_d     = '0;
				digest_d    = 1'b0;
				if (tlen_s1 > TLEN_W'(MAX_NAME_LENGTH)) begin
					phase_d = PH_IDLE;
					push.v0 = 1'b1;
					push.r0 = make_final(ST_TOO_LONG, '0, 1'b0);
				end else begin
					decl_d = POS_W'(tlen_s1);
					if (tlen_s1 == '0) begin
						phase_d = PH_IDLE;
						push.v0 = 1'b1;
						push.r0 = make_final(ST_OK, '0, 1'b0);
					end
				end
			end else if (phase_q != PH_IDLE) begin
				pos_d = pos_n;
				if (phase_q == PH_VALUE) begin
					vleft_d = vleft_q - POS_W'(1);
					if (vleft_q == POS_W'(1)) begin
						if (pos_n >= decl_q) begin
							phase_d = PH_IDLE;
							push.v0 = 1'b1;
							push.r0 = make_final(ST_OK, count_q, digest_q);
						end else begin
							phase_d = PH_TYPE;
							hbl_d   = '0;
						end
					end
				end else if (!num_done) begin
					// header byte that does not complete a number
					if (hbl_q == 3'd0) begin
						acc_d = '0;
						priority if (byte_s1 == NUM_2B) begin
							if (rem < POS_W'(3)) begin
								phase_d = PH_IDLE;
								push.v0 = 1'b1;
								push.r0 = make_final(ST_INCOMPLETE, count_q, digest_q);
							end else begin
								hbl_d = 3'd2;
							end
						end else if (byte_s1 == NUM_4B) begin
							if (rem < POS_W'(5)) begin
								phase_d = PH_IDLE;
								push.v0 = 1'b1;
								push.r0 = make_final(ST_INCOMPLETE, count_q, digest_q);
							end else begin
								hbl_d = 3'd4;
							end
						end else begin
							// eight-byte form
							phase_d = PH_IDLE;
							push.v0 = 1'b1;
							if (rem < POS_W'(9)) begin
								push.r0 = make_final(ST_INCOMPLETE, count_q, digest_q);
							end else begin
								push.r0 = make_final(ST_OVERFLOW, count_q, digest_q);
							end
						end
					end else begin
						acc_d = acc_n;
						hbl_d = hbl_q - 3'd1;
					end
				end else begin
					// a type or length number is complete
					acc_d = (hbl_q == 3'd0) ? '0 : acc_n;
					hbl_d = '0;
					if (phase_q == PH_TYPE) begin
						bad_type_d  = (num_val == '0) || (|num_val[NUM_W-1:TLEN_W]);
						is_digest_d = (num_val == DIGEST_TYPE);
						if (pos_n >= decl_q) begin
							phase_d = PH_IDLE;
							push.v0 = 1'b1;
							push.r0 = make_final(ST_INCOMPLETE, count_q, digest_q);
						end else begin
							phase_d = PH_LEN;
						end
					end else begin
						priority if (far) begin
							phase_d = PH_IDLE;
							push.v0 = 1'b1;
							push.r0 = make_final(ST_INCOMPLETE, count_q, digest_q);
						end else if (bad_type_q) begin
							phase_d = PH_IDLE;
							push.v0 = 1'b1;
							push.r0 = make_final(ST_BAD_TYPE, count_q, digest_q);
						end else if (is_digest_q && num_val != DIGEST_LEN) begin
							phase_d = PH_IDLE;
							push.v0 = 1'b1;
							push.r0 = make_final(ST_BAD_DIGEST, count_q, digest_q);
						end else begin
							digest_d                = digest_n;
							count_d                 = count_n;
							push.v0                 = 1'b1;
							push.r0.kind            = KIND_COMP;
							push.r0.status          = ST_OK;
							push.r0.comp_end_offset = END_W'(end_w);
							push.r0.comp_index      = count_q[IDX_W-1:0];
							push.r0.offset_cached   = count_q < CNT_W'(CACHED_COMPONENTS);
							push.r0.comp_total      = count_n;
							push.r0.digest_present  = digest_n;
							if (num_val == '0) begin
								if (pos_n >= decl_q) begin
									phase_d = PH_IDLE;
									push.v1 = 1'b1;
									push.r1 = make_final(ST_OK, count_n, digest_n);
								end else begin
									phase_d = PH_TYPE;
								end
							end else begin
								vleft_d = num_val[POS_W-1:0];
								phase_d = PH_VALUE;
							end
						end
					end
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			hbl_q       <= '0;
			acc_q       <= '0;
			bad_type_q  <= 1'b0;
			is_digest_q <= 1'b0;
			vleft_q     <= '0;
			pos_q       <= '0;
			decl_q      <= '0;
			count_q     <= '0;
			digest_q    <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			hbl_q       <= hbl_d;
			acc_q       <= acc_d;
			bad_type_q  <= bad_type_d;
			is_digest_q <= is_digest_d;
			vleft_q     <= vleft_d;
			pos_q       <= pos_d;
			decl_q      <= decl_d;
			count_q     <= count_d;
			digest_q    <= digest_d;
		end
	end

endmodule

### hdl/tnp_result_queue.sv
// four-entry result queue, takes up to two words a cycle
module tnp_result_queue
	import tnp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  tnp_push_t     push,
	output logic          room,
	tnp_result_if.source  result
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	tnp_result_t      entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   level_q;
	logic             pop;
	logic [1:0]       n_push;
	tnp_result_t      head;

	assign room   = level_q <= (PTR_W+1)'(DEPTH - 2);
	assign pop    = result.valid && result.ready;
	assign n_push = {1'b0, push.v0} + {1'b0, push.v1};
	assign head   = entry_q[rd_q];

	// output word from the head entry
	assign result.valid           = level_q != '0;
	assign result.kind            = head.kind;
	assign result.status          = head.status;
	assign result.comp_end_offset = head.comp_end_offset;
	assign result.comp_index      = head.comp_index;
	assign result.offset_cached   = head.offset_cached;
	assign result.comp_total      = head.comp_total;
	assign result.digest_present  = head.digest_present;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(n_push);
			rd_q    <= rd_q + PTR_W'(pop);
			level_q <= level_q + (PTR_W+1)'(n_push) - (PTR_W+1)'(pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push.v0) begin
			entry_q[wr_q] <= push.r0;
		end
		if (push.v1) begin
			entry_q[wr_q + PTR_W'(1)] <= push.r1;
		end
	end

endmodule

### hdl/tlv_name_component_parser.sv
// top level of the name component parser
//
//  channel  dir  words
//  item     in   mode, total_length, data_byte
//  result   out  kind, status, comp_end_offset, comp_index, offset_cached,
//                comp_total, digest_present
//
// one input word a cycle while the queue has room; results pass the word register, then a queue entry
// the word register feeds one pass of header/bounds logic into a four-entry queue
// a word moves on only while the queue has room for two results
// asynchronous reset clears parser state and queue, no clearing pass
`include "assert_macros.svh"

module tlv_name_component_parser
	import tnp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	tnp_item_if.sink     item,
	tnp_result_if.source result
);

	tnp_push_t push;
	logic      room;

	tnp_parse_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.room   (room),
		.push   (push)
	);

	tnp_result_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.result (result)
	);

	// checks on parser and queue
	`ASSERT_IMPLIES(a_second_needs_first, clk, arst_n, push.v1, push.v0)
	`ASSERT_IMPLIES(a_pair_order, clk, arst_n, push.v1,
		(push.r0.kind == KIND_COMP) && (push.r1.kind == KIND_FINAL))
	`ASSERT_IMPLIES(a_push_with_room, clk, arst_n, push.v0, room)
	`ASSERT_NEXT(a_push_shows, clk, arst_n, push.v0, result.valid)

endmodule

### tb/tlv_name_component_parser_test.sv
// self-checking testbench for the name component parser: directed rows, random names, scoreboard
`timescale 1ns / 1ps

module tlv_name_component_parser_test;
	import tnp_pkg::*;

	localparam logic [31:0] TYPE_DIGEST  = 32'd1;
	localparam logic [31:0] DIGEST_BYTES = 32'd32;
	localparam logic [31:0] TYPE_LIMIT   = 32'd65535;
	localparam logic [7:0]  MARK_TWO     = 8'd253;
	localparam logic [7:0]  MARK_FOUR    = 8'd254;
	localparam logic [7:0]  MARK_EIGHT   = 8'd255;
	localparam int          RANDOM_WORDS = 1330;
	localparam int          HOLD_CYCLES  = 80;
	localparam int          REPORT_LIMIT = 10;

	typedef enum logic [1:0] {PH_IDLE, PH_TYPE, PH_LEN, PH_VALUE} parse_phase_e;
	typedef enum int {NUM_SHORT, NUM_TWO, NUM_FOUR, NUM_EIGHT} num_form_e;

	// one directed row; typed rows carry a hand-written final result, or none, in place of the prediction
	typedef struct {
		logic            mode;
		logic [15:0]     total_length;
		logic [7:0]      data_byte;
		bit              typed;
		bit              has_result;
		logic [ST_W-1:0] status;
	} stim_row_t;

	logic clk;
	logic arst_n;

	tnp_item_if   item_ch();
	tnp_result_if res_ch();

	tlv_name_component_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch)
	);

	// parser model state
	parse_phase_e ph;
	logic [3:0]   hdr_left;
	logic [31:0]  hdr_acc;
	logic         bad_type;
	logic         is_digest;
	logic [31:0]  val_left;
	logic [11:0]  pos;
	logic [11:0]  decl;
	logic [11:0]  ncomp;
	logic         dig_seen;

	tnp_result_t pending_results[$];
	tnp_result_t word_results[$];
	stim_row_t   dir_rows[$];
	logic [7:0]  name_bytes[$];

	int  fail_count;
	int  results_seen;
	int  words_done;
	bit  steady;
	bit  hold_done;

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic bit take_break();
		return !steady && ($urandom_range(0, 99) < 38);
	endfunction

	function automatic string show(input tnp_result_t r);
		return $sformatf("kind %0d status %0d end %0d idx %0d cached %0d total %0d digest %0d",
			r.kind, r.status, r.comp_end_offset, r.comp_index, r.offset_cached,
			r.comp_total, r.digest_present);
	endfunction

	// ---------------------------------------------------------------- predictor

	task automatic close_name(input logic [ST_W-1:0] st);
		tnp_result_t r;
		r                = '0;
		r.kind           = KIND_FINAL;
		r.status         = st;
		r.comp_total     = ncomp;
		r.digest_present = dig_seen;
		word_results.push_back(r);
		ph = PH_IDLE;
	endtask

	// end of a component: close the name or look for the next type
	task automatic name_boundary();
		if (pos >= decl) begin
			close_name(ST_OK);
		end else begin
			ph       = PH_TYPE;
			hdr_left = '0;
		end
	endtask

	task automatic finish_number(input logic [31:0] v);
		logic [32:0] stop_at;
		tnp_result_t r;
		if (ph == PH_TYPE) begin
			bad_type  = (v < 1) || (v > TYPE_LIMIT);
			is_digest = (v == TYPE_DIGEST);
			if (pos >= decl) begin
				close_name(ST_INCOMPLETE);
			end else begin
				ph       = PH_LEN;
				hdr_left = '0;
			end
		end else begin
			stop_at = {21'd0, pos} + {1'b0, v};
			if (stop_at > {21'd0, decl}) begin
				close_name(ST_INCOMPLETE);
			end else if (bad_type) begin
				close_name(ST_BAD_TYPE);
			end else if (is_digest && v != DIGEST_BYTES) begin
				close_name(ST_BAD_DIGEST);
			end else begin
				if (is_digest)
					dig_seen = 1'b1;
				r                 = '0;
				r.kind            = KIND_COMP;
				r.status          = ST_OK;
				r.comp_end_offset = stop_at[11:0];
				r.comp_index      = ncomp[10:0];
				r.offset_cached   = (ncomp < CACHED_COMPONENTS);
				ncomp             = ncomp + 12'd1;
				r.comp_total      = ncomp;
				r.digest_present  = dig_seen;
				word_results.push_back(r);
				if (v == 0) begin
					name_boundary();
				end else begin
					val_left = v;
					ph       = PH_VALUE;
				end
			end
		end
	endtask

	task automatic clear_parser();
		ph        = PH_IDLE;
		hdr_left  = '0;
		hdr_acc   = '0;
		bad_type  = 1'b0;
		is_digest = 1'b0;
		val_left  = '0;
		pos       = '0;
		decl      = '0;
		ncomp     = '0;
		dig_seen  = 1'b0;
	endtask

	// one accepted word, results appended to word_results
	task automatic parse_word(input logic m, input logic [15:0] tl, input logic [7:0] b);
		logic [31:0] rem;
		if (m == MODE_START) begin
			clear_parser();
			if (tl > MAX_NAME_LENGTH) begin
				close_name(ST_TOO_LONG);
			end else begin
				decl = tl[11:0];
				ph   = PH_TYPE;
				if (tl == 0)
					close_name(ST_OK);
			end
		end else if (ph != PH_IDLE) begin
			rem = {20'd0, decl} - {20'd0, pos};
			pos = pos + 12'd1;
			if (ph == PH_VALUE) begin
				val_left = val_left - 32'd1;
				if (val_left == 0)
					name_boundary();
			end else if (hdr_left == 0) begin
				hdr_acc = '0;
				if (b < MARK_TWO) begin
					finish_number({24'd0, b});
				end else if (b == MARK_TWO) begin
					if (rem < 3)
						close_name(ST_INCOMPLETE);
					else
						hdr_left = 4'd2;
				end else if (b == MARK_FOUR) begin
					if (rem < 5)
						close_name(ST_INCOMPLETE);
					else
						hdr_left = 4'd4;
				end else if (rem < 9) begin
					close_name(ST_INCOMPLETE);
				end else begin
					close_name(ST_OVERFLOW);
				end
			end else begin
				hdr_acc  = {hdr_acc[23:0], b};
				hdr_left = hdr_left - 4'd1;
				if (hdr_left == 0)
					finish_number(hdr_acc);
			end
		end
	endtask

	// ---------------------------------------------------------------- driving

	// offer one word at the falling edge, hold it until taken
	task automatic send_word(input logic m, input logic [15:0] tl, input logic [7:0] b,
			input bit typed, input bit has_result, input logic [ST_W-1:0] st);
		tnp_result_t r;
		bit          counts;
		@(negedge clk);
		while (take_break()) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.mode         <= m;
		item_ch.total_length <= tl;
		item_ch.data_byte    <= b;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		counts = (m == MODE_START) || (ph != PH_IDLE);
		word_results.delete();
		parse_word(m, tl, b);
		if (typed) begin
			if (has_result) begin
				r                = '0;
				r.kind           = KIND_FINAL;
				r.status         = st;
				pending_results.push_back(r);
			end
		end else begin
			foreach (word_results[i])
				pending_results.push_back(word_results[i]);
		end
		if (counts)
			words_done++;
		steady = (words_done >= 500) && (words_done < 700);
	endtask

	function automatic void add_row(input logic m, input logic [15:0] tl, input logic [7:0] b,
			input bit typed, input bit has_result, input logic [ST_W-1:0] st);
		stim_row_t row;
		row.mode         = m;
		row.total_length = tl;
		row.data_byte    = b;
		row.typed        = typed;
		row.has_result   = has_result;
		row.status       = st;
		dir_rows.push_back(row);
	endfunction

	// variable-size number in the chosen form
	task automatic put_number(input logic [31:0] v, input num_form_e form);
		unique case (form)
			NUM_SHORT: begin
				name_bytes.push_back(v[7:0]);
			end
			NUM_TWO: begin
				name_bytes.push_back(MARK_TWO);
				name_bytes.push_back(v[15:8]);
				name_bytes.push_back(v[7:0]);
			end
			NUM_FOUR: begin
				name_bytes.push_back(MARK_FOUR);
				name_bytes.push_back(v[31:24]);
				name_bytes.push_back(v[23:16]);
				name_bytes.push_back(v[15:8]);
				name_bytes.push_back(v[7:0]);
			end
			default: begin
				name_bytes.push_back(MARK_EIGHT);
				repeat (8)
					name_bytes.push_back(8'($urandom_range(0, 255)));
			end
		endcase
	endtask

	// mostly well-formed names with random content, some cut, padded, oversized or empty
	task automatic send_random_name();
		int          want;
		int          roll;
		int          total;
		int          nsend;
		logic [31:0] tv;
		logic [31:0] lv;
		num_form_e   tf;
		num_form_e   lf;
		bit          stop;
		name_bytes.delete();
		stop = 1'b0;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			want = $urandom_range(0, 5);
		else if (roll < 90)
			want = $urandom_range(6, 12);
		else
			want = $urandom_range(14, 20);
		for (int c = 0; c < want && !stop; c++) begin
			// type number
			roll = $urandom_range(0, 99);
			tf   = NUM_SHORT;
			if (roll < 8) begin
				tv = TYPE_DIGEST;
			end else if (roll < 12) begin
				tf = NUM_TWO;
				tv = $urandom_range(0, 65535);
			end else if (roll < 15) begin
				tf = NUM_FOUR;
				tv = $urandom();
			end else if (roll < 17) begin
				tv = '0;
			end else if (roll < 18) begin
				tf = NUM_EIGHT;
				tv = '0;
			end else begin
				tv = $urandom_range(2, 252);
			end
			put_number(tv, tf);
			// length number and value
			roll = $urandom_range(0, 99);
			lf   = NUM_SHORT;
			if (tv == TYPE_DIGEST) begin
				lv = (roll < 85) ? DIGEST_BYTES : 32'($urandom_range(0, 40));
			end else if (roll < 60) begin
				lv = $urandom_range(0, 4);
			end else if (roll < 72) begin
				lv = '0;
			end else if (roll < 82) begin
				lf = NUM_TWO;
				lv = $urandom_range(0, 8);
			end else if (roll < 90) begin
				lf = NUM_FOUR;
				lv = $urandom_range(0, 8);
			end else if (roll < 94) begin
				lf = NUM_FOUR;
				lv = $urandom();
			end else begin
				lv = $urandom_range(5, 24);
			end
			put_number(lv, lf);
			if (lv > 64) begin
				stop = 1'b1;
			end else begin
				repeat (lv)
					name_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
		// declared length
		total = name_bytes.size();
		roll  = $urandom_range(0, 99);
		if (roll < 8 && total > 0)
			total = total - $urandom_range(1, (total < 3) ? total : 3);
		else if (roll < 14)
			total = total + $urandom_range(1, 3);
		else if (roll < 18)
			total = $urandom_range(MAX_NAME_LENGTH + 1, 65535);
		else if (roll < 20)
			total = 0;
		send_word(MODE_START, 16'(total), 8'($urandom_range(0, 255)), 1'b0, 1'b0, ST_OK);
		nsend = (total > MAX_NAME_LENGTH) ? $urandom_range(0, 3) : total;
		// restart in the middle of a name now and then
		if ($urandom_range(0, 99) < 5 && nsend > 1)
			nsend = $urandom_range(1, nsend - 1);
		for (int i = 0; i < nsend; i++)
			send_word(MODE_DATA, 16'($urandom_range(0, 65535)),
				(i < name_bytes.size()) ? name_bytes[i] : 8'($urandom_range(0, 255)),
				1'b0, 1'b0, ST_OK);
		// stray bytes after the name
		if ($urandom_range(0, 99) < 5)
			repeat ($urandom_range(1, 2))
				send_word(MODE_DATA, 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)), 1'b0, 1'b0, ST_OK);
	endtask

	// ---------------------------------------------------------------- checking

	task automatic note_failure(input string what, input tnp_result_t want,
			input tnp_result_t got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%0t %s\n  expected %s\n  actual   %s", $realtime, what, show(want),
				show(got));
	endtask

	// every accepted result word against the oldest expectation
	always @(posedge clk) begin
		tnp_result_t got;
		tnp_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.kind            = res_ch.kind;
			got.status          = res_ch.status;
			got.comp_end_offset = res_ch.comp_end_offset;
			got.comp_index      = res_ch.comp_index;
			got.offset_cached   = res_ch.offset_cached;
			got.comp_total      = res_ch.comp_total;
			got.digest_present  = res_ch.digest_present;
			results_seen++;
			if (pending_results.size() == 0) begin
				note_failure("result word with nothing expected", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind || got.status !== want.status ||
						got.comp_end_offset !== want.comp_end_offset ||
						got.comp_index !== want.comp_index ||
						got.offset_cached !== want.offset_cached ||
						got.comp_total !== want.comp_total ||
						got.digest_present !== want.digest_present)
					note_failure("result word mismatch", want, got);
			end
		end
	end

	// result side: random stalls, one long hold-off so the input backs up
	initial begin
		int held;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 100) begin
				res_ch.ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(negedge clk);
				hold_done = 1'b1;
			end else begin
				res_ch.ready <= !take_break();
			end
		end
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		item_ch.valid        = 1'b0;
		item_ch.mode         = MODE_START;
		item_ch.total_length = '0;
		item_ch.data_byte    = '0;
		arst_n               = 1'b0;
		fail_count           = 0;
		results_seen         = 0;
		words_done           = 0;
		steady               = 1'b0;
		hold_done            = 1'b0;
		clear_parser();

		// directed rows
		add_row(MODE_DATA,  16'd0,     8'h5a, 1, 0, ST_OK);        // stray byte, no name open
		add_row(MODE_START, 16'd0,     8'h00, 1, 1, ST_OK);        // empty name
		add_row(MODE_START, 16'd65535, 8'hff, 1, 1, ST_TOO_LONG);
		add_row(MODE_START, 16'd2049,  8'h00, 1, 1, ST_TOO_LONG);  // just over the limit
		add_row(MODE_START, 16'd2048,  8'h00, 1, 0, ST_OK);        // longest allowed, dropped next
		add_row(MODE_START, 16'd6,     8'h00, 0, 0, ST_OK);        // restart while open
		add_row(MODE_DATA,  16'd0,     8'h08, 0, 0, ST_OK);
		add_row(MODE_DATA,  16'd0,     8'h00, 0, 0, ST_OK);        // empty component
		add_row(MODE_DATA,  16'd0,     MARK_TWO, 0, 0, ST_OK);     // two-byte type
		add_row(MODE_DATA,  16'd0,     8'h00, 0, 0, ST_OK);
		add_row(MODE_DATA,  16'd0,     8'h07, 0, 0, ST_OK);
		add_row(MODE_DATA,  16'd0,     8'h00, 0, 0, ST_OK);        // last one empty: two results
		add_row(MODE_START, 16'd12,    8'h00, 0, 0, ST_OK);
		add_row(MODE_DATA,  16'd0,     MARK_EIGHT, 1, 1, ST_OVERFLOW);
		add_row(MODE_START, 16'd8,     8'h00, 0, 0, ST_OK);
		add_row(MODE_DATA,  16'd0,     8'h01, 0, 0, ST_OK);        // digest type
		add_row(MODE_DATA,  16'd0,     8'h05, 0, 0, ST_OK);        // wrong digest length
		add_row(MODE_START, 16'd1,     8'h00, 0, 0, ST_OK);
		add_row(MODE_DATA,  16'd0,     8'h08, 1, 1, ST_INCOMPLETE); // type then end of name
		add_row(MODE_START, 16'd7,     8'h00, 0, 0, ST_OK);
		add_row(MODE_DATA,  16'd0,     8'h08, 0, 0, ST_OK);
		add_row(MODE_DATA,  16'd0,     MARK_FOUR, 0, 0, ST_OK);    // huge length number
		add_row(MODE_DATA,  16'd0,     8'hff, 0, 0, ST_OK);
		add_row(MODE_DATA,  16'd0,     8'hff, 0, 0, ST_OK);
		add_row(MODE_DATA,  16'd0,     8'hff, 0, 0, ST_OK);
		add_row(MODE_DATA,  16'd0,     8'hff, 0, 0, ST_OK);
		add_row(MODE_START, 16'd10,    8'h00, 0, 0, ST_OK);
		add_row(MODE_DATA,  16'd0,     8'h00, 0, 0, ST_OK);        // type zero
		add_row(MODE_DATA,  16'd0,     8'h01, 0, 0, ST_OK);

		// reset
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_word(dir_rows[i].mode, dir_rows[i].total_length, dir_rows[i].data_byte,
				dir_rows[i].typed, dir_rows[i].has_result, dir_rows[i].status);

		// random names
		words_done = 0;
		while (words_done < RANDOM_WORDS)
			send_random_name();

		@(negedge clk);
		item_ch.valid <= 1'b0;

		// drain, then leave time for anything unexpected
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog
	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

endmodule

### tlv_name_component_parser.f
+incdir+hdl
hdl/tnp_pkg.sv
hdl/tnp_ifs.sv
hdl/tnp_parse_core.sv
hdl/tnp_result_queue.sv
hdl/tlv_name_component_parser.sv
tb/tlv_name_component_parser_test.sv
